### src/mmcrc_pkg.sv
// package for the multi-mode crc engine: mode codes, register indexes,
// polynomial constants and the byte-wide crc update functions
// no dependencies
package mmcrc_pkg;

    // mode codes held in the crc_mode register
    localparam logic [2:0] MODE_CRC8   = 3'd0;
    localparam logic [2:0] MODE_CRC16  = 3'd1;
    localparam logic [2:0] MODE_CCITT  = 3'd2;
    localparam logic [2:0] MODE_KERMIT = 3'd3;
    localparam logic [2:0] MODE_CRC32  = 3'd4;

    // register index, taken from paddr bit 2
    localparam logic REG_CRC_MODE   = 1'b0;
    localparam logic REG_BIG_ENDIAN = 1'b1;

    // polynomials and fixed values
    localparam logic [7:0]  CRC8_POLY   = 8'hD5;
    localparam logic [15:0] CRC16_POLY  = 16'hA001;
    localparam logic [15:0] CCITT_POLY  = 16'h1021;
    localparam logic [15:0] KERMIT_POLY = 16'h8408;
    localparam logic [31:0] CRC32_POLY  = 32'hEDB88320;
    localparam logic [31:0] CRC32_INIT  = 32'hFFFFFFFF;
    localparam logic [7:0]  CRC8_XOROUT = 8'hFF;

    // reset values of the configuration registers
    localparam logic [2:0] CRC_MODE_RST   = MODE_CRC32;
    localparam logic       BIG_ENDIAN_RST = 1'b1;

    // 8-bit msb-first update, one byte
    function automatic logic [7:0] crc8_msb(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] r;
        r = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            r = r[7] ? ({r[6:0], 1'b0} ^ CRC8_POLY) : {r[6:0], 1'b0};
        end
        return r;
    endfunction

    // 16-bit msb-first update, one byte
    function automatic logic [15:0] crc16_msb(input logic [15:0] crc, input logic [7:0] data,
                                              input logic [15:0] poly);
        logic [15:0] r;
        r = crc ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            r = r[15] ? ({r[14:0], 1'b0} ^ poly) : {r[14:0], 1'b0};
        end
        return r;
    endfunction

    // 16-bit reflected update, one byte
    function automatic logic [15:0] crc16_lsb(input logic [15:0] crc, input logic [7:0] data,
                                              input logic [15:0] poly);
        logic [15:0] r;
        r = crc ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? ({1'b0, r[15:1]} ^ poly) : {1'b0, r[15:1]};
        end
        return r;
    endfunction

    // 32-bit reflected update, one byte
    function automatic logic [31:0] crc32_lsb(input logic [31:0] crc, input logic [7:0] data);
        logic [31:0] r;
        r = crc ^ {24'h000000, data};
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? ({1'b0, r[31:1]} ^ CRC32_POLY) : {1'b0, r[31:1]};
        end
        return r;
    endfunction

endpackage

### src/multi_mode_crc_engine_top.sv
// top level of the multi-mode crc engine: apb config registers, input stage,
// byte-wide crc update and result register
// depends on mmcrc_pkg
//
// Byte-wise CRC engine with five modes selected by crc_mode (0 CRC-8, 1 CRC-16,
// 2 CCITT, 3 Kermit, 4 CRC-32; codes 5 to 7 act as CRC-32). It takes one byte
// per cycle, but a chunk_end byte stalls while the result register is full and
// not taken: a byte lands in the input stage, the eight-bit update of the
// single running crc register is done from there, and a byte marked chunk_end
// loads the finished value into the result register. The running register is
// what limits the rate to one byte per cycle. restart reloads the mode's initial
// value before its byte; writing crc_mode reloads it too. With big_endian at 0
// 16- and 32-bit results come out byte-swapped. Write configuration only while
// no transfer is in flight.
module multi_mode_crc_engine_top
    import mmcrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // apb configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        restart,
    input  logic        chunk_end,
    // result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] crc_value
);

    logic [2:0]  crc_mode_reg;
    logic        big_endian_reg;
    logic [31:0] crc_reg;
    logic [31:0] crc_next;

    logic        stage_valid_reg;
    logic [7:0]  stage_data_reg;
    logic        stage_restart_reg;
    logic        stage_last_reg;

    logic        out_valid_reg;
    logic [31:0] crc_value_reg;

    logic        cfg_wr;
    logic        mode_wr;
    logic        stage_adv;
    logic        in_xfer;
    logic [2:0]  eff_mode;
    logic [2:0]  new_mode;
    logic [31:0] new_init;
    logic [31:0] crc_base;
    logic [31:0] res_raw;
    logic [31:0] res_final;

    // apb decode
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign mode_wr = cfg_wr && (paddr[2] == REG_CRC_MODE);
    assign new_mode = pwdata[2:0];
    assign new_init = (new_mode >= MODE_CRC32) ? CRC32_INIT : 32'h00000000;

    // register readback
    always_comb
    begin
        unique case (paddr[2])
            REG_CRC_MODE:   prdata = {29'h0, crc_mode_reg};
            REG_BIG_ENDIAN: prdata = {31'h0, big_endian_reg};
            default:        prdata = 32'h00000000;
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_mode_reg   <= CRC_MODE_RST;
            big_endian_reg <= BIG_ENDIAN_RST;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_CRC_MODE)
            begin
                crc_mode_reg <= new_mode;
            end
            else
            begin
                big_endian_reg <= pwdata[0];
            end
        end
    end

    // handshake: stage moves on unless it holds a chunk end and the result slot is busy
    assign stage_adv = stage_valid_reg && (!stage_last_reg || !out_valid_reg || out_ready);
    assign in_ready  = !stage_valid_reg || stage_adv;
    assign in_xfer   = in_valid && in_ready;

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            stage_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            stage_data_reg    <= data_byte;
            stage_restart_reg <= restart;
            stage_last_reg    <= chunk_end;
        end
    end

    // byte update of the running crc
    always_comb
    begin
        eff_mode = (crc_mode_reg > MODE_CRC32) ? MODE_CRC32 : crc_mode_reg;
        if (stage_restart_reg)
        begin
            crc_base = (eff_mode == MODE_CRC32) ? CRC32_INIT : 32'h00000000;
        end
        else
        begin
            crc_base = crc_reg;
        end
        unique case (eff_mode)
            MODE_CRC8:
            begin
                crc_next = {24'h0, crc8_msb(crc_base[7:0], stage_data_reg)};
                res_raw  = crc_next ^ {24'h0, CRC8_XOROUT};
            end
            MODE_CRC16:
            begin
                crc_next = {16'h0, crc16_lsb(crc_base[15:0], stage_data_reg, CRC16_POLY)};
                res_raw  = crc_next;
            end
            MODE_CCITT:
            begin
                crc_next = {16'h0, crc16_msb(crc_base[15:0], stage_data_reg, CCITT_POLY)};
                res_raw  = crc_next;
            end
            MODE_KERMIT:
            begin
                crc_next = {16'h0, crc16_lsb(crc_base[15:0], stage_data_reg, KERMIT_POLY)};
                res_raw  = crc_next;
            end
            default:
            begin
                crc_next = crc32_lsb(crc_base, stage_data_reg);
                res_raw  = ~crc_next;
            end
        endcase
    end

    // optional byte swap; an 8-bit result is never swapped
    always_comb
    begin
        if (big_endian_reg || (eff_mode == MODE_CRC8))
        begin
            res_final = res_raw;
        end
        else if (eff_mode == MODE_CRC32)
        begin
            res_final = {res_raw[7:0], res_raw[15:8], res_raw[23:16], res_raw[31:24]};
        end
        else
        begin
            res_final = {16'h0, res_raw[7:0], res_raw[15:8]};
        end
    end

    // running crc register; a mode write reloads the initial value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= CRC32_INIT;
        end
        else if (mode_wr)
        begin
            crc_reg <= new_init;
        end
        else if (stage_adv)
        begin
            crc_reg <= crc_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stage_adv && stage_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_adv && stage_last_reg)
        begin
            crc_value_reg <= res_final;
        end
    end

    assign out_valid = out_valid_reg;
    assign crc_value = crc_value_reg;

`ifndef ASSERT_OFF
    // a mode write leaves the running crc at the new mode's initial value
    a_mode_reload: assert property (@(posedge clk) disable iff (!rst_n)
        mode_wr |=> (crc_reg == ((crc_mode_reg >= MODE_CRC32) ? CRC32_INIT : 32'h0)))
        else $error("crc register not reloaded after mode write");

    // narrow modes keep the unused upper bits of the running crc at zero
    a_narrow_upper: assert property (@(posedge clk) disable iff (!rst_n)
        (crc_mode_reg < MODE_CRC32) |-> (crc_reg[31:16] == 16'h0))
        else $error("upper crc bits set in a 16- or 8-bit mode");

    // a stalled chunk end stays in the input stage until the result slot frees
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && !stage_adv) |=> (stage_valid_reg && $stable(stage_data_reg)))
        else $error("stalled byte lost from input stage");
`endif

endmodule
